// File: hw/rtl/ufcc_pkg.sv
`default_nettype none

package ufcc_pkg;

  localparam int unsigned NODES_DEF = 4096;
  localparam int unsigned FIELD_W   = 12;
  localparam int unsigned OP_W      = 2;

  localparam logic [FIELD_W-1:0] NODE_COUNT_RST = 12'd4095;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_MERGE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/union_find_constraint_checker.sv
// channel  direction  handshake              payload
// input    in         in_valid / in_ready    operation, node_a, node_b
// result   out        out_valid / out_ready  same_set, conflict
// config   in         cfg_wen                cfg_wdata (node_count)
//
// merge and check walk each node's parent chain to its root and then rewrite the nodes on
// that path to point at the root (path compression); every hop or rewrite is one access
// of the single-port-read parent memory. unused codes skip the table and give a result.
// clear rewrites rows 0 to node_count (at most NODES-1), one memory row per cycle.
// after rst a clearing pass writes all NODES rows, one a cycle, before in_ready rises.
// a finished word waits in the output register; the next word is taken meanwhile.
`default_nettype none

module union_find_constraint_checker #(
  parameter int unsigned NODES = ufcc_pkg::NODES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wen,
  input  wire logic [ufcc_pkg::FIELD_W-1:0] cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [ufcc_pkg::OP_W-1:0]    operation,
  input  wire logic [ufcc_pkg::FIELD_W-1:0] node_a,
  input  wire logic [ufcc_pkg::FIELD_W-1:0] node_b,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              same_set,
  output logic                              conflict
);

  localparam int unsigned FW    = ufcc_pkg::FIELD_W;
  localparam int unsigned IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned RECIP = ((32'd1 << 24) + NODES - 1) / NODES;
  localparam int unsigned PROD_W = FW + 25;
  localparam int unsigned REM_W  = FW + IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NODES - 1);
  localparam logic [31:0] LAST_32 = 32'(NODES - 1);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WRAP  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_COMP  = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                  state;
  logic [FW-1:0]               node_count;
  logic                        conflict_seen;
  logic [ufcc_pkg::OP_W-1:0]   op;
  logic [FW-1:0]               a_raw;
  logic [FW-1:0]               b_raw;
  logic [FW-1:0]               qa;
  logic [FW-1:0]               qb;
  logic [IDX_W-1:0]            cur;
  logic [IDX_W-1:0]            start;
  logic [IDX_W-1:0]            bi;
  logic [IDX_W-1:0]            root;
  logic [IDX_W-1:0]            ra;
  logic                        second;
  logic [IDX_W-1:0]            cnt;
  logic [IDX_W-1:0]            top;
  logic                        res_same;

  logic [IDX_W-1:0]            mem [NODES];
  logic [IDX_W-1:0]            pdata;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [IDX_W-1:0]            mem_wdata;
  logic [IDX_W-1:0]            mem_raddr;

  logic [PROD_W-1:0]           prod_a;
  logic [PROD_W-1:0]           prod_b;
  logic [REM_W-1:0]            rem_a;
  logic [REM_W-1:0]            rem_b;
  logic [IDX_W-1:0]            ia;
  logic [IDX_W-1:0]            ib;
  logic [IDX_W-1:0]            sweep_last;
  logic                        accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // index wrap modulo NODES: reciprocal quotient at accept, remainder in the next cycle
  assign prod_a = PROD_W'(node_a) * PROD_W'(RECIP);
  assign prod_b = PROD_W'(node_b) * PROD_W'(RECIP);
  assign rem_a  = REM_W'(a_raw) - REM_W'(qa) * REM_W'(NODES);
  assign rem_b  = REM_W'(b_raw) - REM_W'(qb) * REM_W'(NODES);
  assign ia     = rem_a[IDX_W-1:0];
  assign ib     = rem_b[IDX_W-1:0];

  assign sweep_last = (state == S_INIT) ? LAST : top;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = cnt;
    mem_raddr = cur;
    unique case (state) inside
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_WRAP: begin
        mem_raddr = ia;
      end
      S_WALK: begin
        mem_raddr = (pdata == cur) ? start : pdata;
      end
      S_COMP: begin
        if (cur != root) begin
          mem_we    = 1'b1;
          mem_waddr = cur;
          mem_wdata = root;
          mem_raddr = pdata;
        end else begin
          mem_raddr = bi;
          if (second && op == ufcc_pkg::OP_MERGE && ra != root) begin
            mem_we    = 1'b1;
            mem_waddr = ra;
            mem_wdata = root;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    pdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= ufcc_pkg::NODE_COUNT_RST;
    end else if (cfg_wen) begin
      node_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      cnt           <= '0;
      conflict_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op       <= operation;
            a_raw    <= node_a;
            b_raw    <= node_b;
            qa       <= prod_a[FW+23:24];
            qb       <= prod_b[FW+23:24];
            second   <= 1'b0;
            res_same <= 1'b0;
            cnt      <= '0;
            top      <= (32'(node_count) > LAST_32) ? LAST : IDX_W'(node_count);
            unique case (operation) inside
              ufcc_pkg::OP_CLEAR: begin
                conflict_seen <= 1'b0;
                state         <= S_CLEAR;
              end
              ufcc_pkg::OP_MERGE, ufcc_pkg::OP_CHECK: begin
                state <= S_WRAP;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_WRAP: begin
          cur   <= ia;
          start <= ia;
          bi    <= ib;
          state <= S_WALK;
        end
        S_WALK: begin
          if (pdata == cur) begin
            root  <= cur;
            cur   <= start;
            state <= S_COMP;
          end else begin
            cur <= pdata;
          end
        end
        S_COMP: begin
          if (cur != root) begin
            cur <= pdata;
          end else if (!second) begin
            ra     <= root;
            second <= 1'b1;
            cur    <= bi;
            start  <= bi;
            state  <= S_WALK;
          end else begin
            res_same <= (ra == root);
            if (op == ufcc_pkg::OP_CHECK && ra == root) begin
              conflict_seen <= 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == sweep_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            same_set  <= res_same;
            conflict  <= conflict_seen;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_we)
    else $error("parent table written while idle");

  a_comp_no_collide: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMP && cur != root) |-> mem_raddr != mem_waddr)
    else $error("compression reads the row it writes");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result word raised outside completion");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted word did not start work");
`endif

endmodule

`default_nettype wire
